>>> design/stq_pkg.sv
// Shared types, codes and constants of the sorted timer event queue.
package stq_pkg;

  localparam logic [9:0]  MS_PER_SEC  = 10'd1000;
  localparam logic [9:0]  STEP_RESET  = 10'd10;
  localparam logic [9:0]  STEP_MAX    = 10'd999;
  localparam int          RESULTS_CAP = 16;
  // floor(n / 1000) == (n * RECIP_1000) >> RECIP_SHIFT for every 32-bit n
  localparam logic [28:0] RECIP_1000  = 29'd274877907;
  localparam int          RECIP_SHIFT = 38;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_ARM    = 2'd1,
    REQ_CANCEL = 2'd2
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_ARMED     = 3'd0,
    ST_EXPIRED   = 3'd1,
    ST_NONE_DUE  = 3'd2,
    ST_FULL      = 3'd3,
    ST_CANCELLED = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_EXP_RD,
    S_EXP_CMP,
    S_EXP_END,
    S_SH_RD,
    S_SH_WR,
    S_DIV,
    S_INS_RD,
    S_INS_CMP,
    S_CAN_RD,
    S_CAN_CMP,
    S_REPLY
  } seq_state_t;

  typedef struct packed {
    logic       tick;
    logic       res_load;
    status_t    res_status;
    logic [7:0] res_task;
    logic       res_last;
  } seq_ctl_t;

endpackage

>>> design/stq_if.sv
// Request and result channel interfaces of the sorted timer event queue.
interface stq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  task_id;
  logic [31:0] delay_ms;

  modport source (output valid, req_type, task_id, delay_ms, input ready);
  modport sink   (input valid, req_type, task_id, delay_ms, output ready);
endinterface

interface stq_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  expired_task;
  logic [31:0] now_seconds;
  logic [9:0]  now_millis;
  logic        last;

  modport source (output valid, status, expired_task, now_seconds, now_millis, last,
                  input ready);
  modport sink   (input valid, status, expired_task, now_seconds, now_millis, last,
                  output ready);
endinterface

>>> design/stq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stq_ram #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/stq_deadline.sv
// Deadline unit: splits a millisecond delay by 1000 and adds it to the time base.
module stq_deadline import stq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] delay,
  input  logic [31:0] now_sec,
  input  logic [9:0]  now_ms,
  output logic        done,
  output logic [31:0] dl_sec,
  output logic [9:0]  dl_ms
);

  logic        v1;
  logic        v2;
  logic [60:0] prod;
  logic [31:0] delay_q;
  logic [22:0] quot;
  logic [9:0]  rem;
  logic [22:0] quot_c;
  logic [31:0] rem_c;
  logic [10:0] ms_sum;
  logic        wrap;

  // Quotient by reciprocal, remainder by multiply back and subtract.
  assign quot_c = prod[RECIP_SHIFT +: 23];
  assign rem_c  = delay_q - (32'(quot_c) * 32'(MS_PER_SEC));
  assign ms_sum = {1'b0, now_ms} + {1'b0, rem};
  assign wrap   = (ms_sum >= {1'b0, MS_PER_SEC});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod    <= 61'(delay) * 61'(RECIP_1000);
      delay_q <= delay;
    end
    if (v1) begin
      quot <= quot_c;
      rem  <= rem_c[9:0];
    end
    if (v2) begin
      dl_sec <= now_sec + 32'(quot) + 32'(wrap);
      dl_ms  <= wrap ? 10'(ms_sum - {1'b0, MS_PER_SEC}) : ms_sum[9:0];
    end
  end

endmodule

>>> design/stq_seq.sv
// Sequencer: walks the entry memory for tick expiry, sorted insert and cancel.
module stq_seq import stq_pkg::*; #(
  parameter int MAX_TIMERS   = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  stq_req_if.sink     req,
  input  logic        res_free,
  input  logic [31:0] now_sec,
  input  logic [9:0]  now_ms,
  output logic        dl_start,
  input  logic        dl_done,
  input  logic [31:0] dl_sec,
  input  logic [9:0]  dl_ms,
  output seq_ctl_t    ctl
);

  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam int IW = $clog2(MAX_TIMERS);
  localparam int EW = 42 + TASK_ID_BITS;

  seq_state_t              state;
  seq_state_t              state_next;
  logic [CW-1:0]           count;
  logic [CW-1:0]           ptr;
  logic [CW-1:0]           skip;
  logic                    found;
  logic                    pend;
  logic [TASK_ID_BITS-1:0] pend_task;
  logic [TASK_ID_BITS-1:0] req_task;
  status_t                 reply;

  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  logic [EW-1:0]           ram_wdata;
  logic [IW-1:0]           ram_raddr;
  logic [EW-1:0]           rdata;

  logic [31:0]             e_sec;
  logic [9:0]              e_ms;
  logic [TASK_ID_BITS-1:0] e_task;
  logic [EW-1:0]           new_entry;
  logic [31:0]             a_sec;
  logic [9:0]              a_ms;
  logic [31:0]             b_sec;
  logic [9:0]              b_ms;
  logic                    le;
  logic                    at_end;
  logic                    exp_stop;
  logic                    full;
  logic                    task_match;
  logic [CW-1:0]           ptr_m1;
  logic [CW-1:0]           sh_dst;

  stq_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign e_sec     = rdata[EW-1 -: 32];
  assign e_ms      = rdata[TASK_ID_BITS +: 10];
  assign e_task    = rdata[TASK_ID_BITS-1:0];
  assign new_entry = {dl_sec, dl_ms, req_task};

  // Shared deadline comparator: new-vs-entry on insert, entry-vs-now on expiry.
  always_comb begin
    if (state == S_INS_CMP) begin
      a_sec = dl_sec;
      a_ms  = dl_ms;
      b_sec = e_sec;
      b_ms  = e_ms;
    end else begin
      a_sec = e_sec;
      a_ms  = e_ms;
      b_sec = now_sec;
      b_ms  = now_ms;
    end
  end

  assign le         = (a_sec < b_sec) || ((a_sec == b_sec) && (a_ms <= b_ms));
  assign at_end     = (ptr == count);
  assign exp_stop   = at_end || (32'(ptr) >= 32'(RESULTS_CAP));
  assign full       = (count == CW'(MAX_TIMERS));
  assign task_match = (e_task == req_task);
  assign ptr_m1     = ptr - CW'(1);
  assign sh_dst     = ptr - skip;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          unique case (req.req_type)
            REQ_TICK:   state_next = S_TICK;
            REQ_ARM:    state_next = full ? S_REPLY : S_DIV;
            REQ_CANCEL: state_next = S_CAN_RD;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_TICK:    state_next = S_EXP_RD;
      S_EXP_RD:  state_next = exp_stop ? S_EXP_END : S_EXP_CMP;
      S_EXP_CMP: begin
        if (!le) begin
          state_next = S_EXP_END;
        end else if (!pend || res_free) begin
          state_next = S_EXP_RD;
        end
      end
      S_EXP_END: begin
        if (res_free) begin
          state_next = pend ? S_SH_RD : S_IDLE;
        end
      end
      S_SH_RD:   state_next = at_end ? S_IDLE : S_SH_WR;
      S_SH_WR:   state_next = S_SH_RD;
      S_DIV: begin
        if (dl_done) begin
          state_next = S_INS_RD;
        end
      end
      S_INS_RD:  state_next = (ptr == '0) ? S_REPLY : S_INS_CMP;
      S_INS_CMP: state_next = le ? S_INS_RD : S_REPLY;
      S_CAN_RD:  state_next = at_end ? S_REPLY : S_CAN_CMP;
      S_CAN_CMP: state_next = S_CAN_RD;
      S_REPLY: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready      = (state == S_IDLE);
    // start the split only for an arm that will be inserted
    dl_start       = req.valid && (state == S_IDLE) && (req.req_type == REQ_ARM) && !full;
    ctl            = '0;
    ctl.res_status = reply;
    ctl.res_task   = 8'(req_task);
    ram_we         = 1'b0;
    ram_waddr      = ptr[IW-1:0];
    ram_wdata      = rdata;
    ram_raddr      = ptr[IW-1:0];
    unique case (state)
      S_TICK: ctl.tick = 1'b1;
      S_EXP_CMP: begin
        // a further due entry exists, so the held one is not the last
        if (le && pend && res_free) begin
          ctl.res_load   = 1'b1;
          ctl.res_status = ST_EXPIRED;
          ctl.res_task   = 8'(pend_task);
          ctl.res_last   = 1'b0;
        end
      end
      S_EXP_END: begin
        if (res_free) begin
          ctl.res_load   = 1'b1;
          ctl.res_last   = 1'b1;
          ctl.res_status = pend ? ST_EXPIRED : ST_NONE_DUE;
          ctl.res_task   = pend ? 8'(pend_task) : 8'd0;
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sh_dst[IW-1:0];
      end
      S_INS_RD: begin
        ram_raddr = ptr_m1[IW-1:0];
        if (ptr == '0) begin
          ram_we    = 1'b1;
          ram_wdata = new_entry;
        end
      end
      S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = le ? rdata : new_entry;
      end
      S_CAN_CMP: begin
        if (found) begin
          ram_we    = 1'b1;
          ram_waddr = ptr_m1[IW-1:0];
        end
      end
      S_REPLY: begin
        if (res_free) begin
          ctl.res_load = 1'b1;
          ctl.res_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_INS_RD: begin
          if (ptr == '0) begin
            count <= count + CW'(1);
          end
        end
        S_INS_CMP: begin
          if (!le) begin
            count <= count + CW'(1);
          end
        end
        S_CAN_RD: begin
          if (at_end && found) begin
            count <= count - CW'(1);
          end
        end
        S_SH_RD: begin
          if (at_end) begin
            count <= count - skip;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          req_task <= TASK_ID_BITS'(req.task_id);
          ptr      <= '0;
          found    <= 1'b0;
          pend     <= 1'b0;
          reply    <= (req.req_type == REQ_ARM) ? ST_FULL : ST_NOT_FOUND;
        end
      end
      S_EXP_CMP: begin
        if (le && (!pend || res_free)) begin
          pend      <= 1'b1;
          pend_task <= e_task;
          ptr       <= ptr + CW'(1);
        end
      end
      S_EXP_END: skip <= ptr;
      S_SH_WR:   ptr  <= ptr + CW'(1);
      S_DIV: begin
        if (dl_done) begin
          ptr <= count;
        end
      end
      S_INS_RD: begin
        if (ptr == '0) begin
          reply <= ST_ARMED;
        end
      end
      S_INS_CMP: begin
        if (le) begin
          ptr <= ptr_m1;
        end else begin
          reply <= ST_ARMED;
        end
      end
      S_CAN_RD: begin
        if (at_end && found) begin
          reply <= ST_CANCELLED;
        end
      end
      S_CAN_CMP: begin
        if (task_match) begin
          found <= 1'b1;
        end
        ptr <= ptr + CW'(1);
      end
      default: ;
    endcase
  end

endmodule

>>> design/sorted_timer_event_queue_core.sv
// Top level of the sorted timer event queue: time base, step register, result register.
//
//   channel  | direction | transaction carries
//   ---------+-----------+-------------------------------------------------------
//   req      | in        | req_type, task_id, delay_ms
//   res      | out       | status, expired_task, now_seconds, now_millis, last
//   cfg      | in        | cfg_wr_en, cfg_wr_data (tick_step_ms, no read-back)
//
// Entry walks: every entry visit is a memory read state followed by a
// compare/write state on the entry memory. Arm first waits in S_DIV for the
// deadline unit, and a tick walk also holds for any output stalls.
// Reset: synchronous; empties the queue, zeroes the time base and loads a
// 10 ms step. The entry memory is not cleared; only live entries are read.
// Stalls: results wait in one output register; the sequencer holds while it
// is full and not draining, and req is ready only between requests.
module sorted_timer_event_queue_core import stq_pkg::*; #(
  parameter int MAX_TIMERS   = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [9:0] cfg_wr_data,
  stq_req_if.sink    req,
  stq_res_if.source  res
);

  logic [9:0]  step;
  logic [9:0]  step_eff;
  logic [31:0] time_sec;
  logic [9:0]  time_ms;
  logic [10:0] ms_sum;
  logic        ms_wrap;

  seq_ctl_t    ctl;
  logic        res_free;
  logic        dl_start;
  logic        dl_done;
  logic [31:0] dl_sec;
  logic [9:0]  dl_ms;

  logic        out_valid;
  logic [2:0]  out_status;
  logic [7:0]  out_task;
  logic [31:0] out_sec;
  logic [9:0]  out_ms;
  logic        out_last;

  // Step register; the user must write it only while the block is idle, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_RESET;
    end else if (cfg_wr_en) begin
      step <= cfg_wr_data;
    end
  end

  // Clamp out-of-range steps, then advance and wrap at one full second.
  assign step_eff = (step > STEP_MAX) ? STEP_MAX : step;
  assign ms_sum   = {1'b0, time_ms} + {1'b0, step_eff};
  assign ms_wrap  = (ms_sum >= {1'b0, MS_PER_SEC});

  always_ff @(posedge clk) begin
    if (rst) begin
      time_sec <= '0;
      time_ms  <= '0;
    end else if (ctl.tick) begin
      time_ms  <= ms_wrap ? 10'(ms_sum - {1'b0, MS_PER_SEC}) : ms_sum[9:0];
      time_sec <= time_sec + 32'(ms_wrap);
    end
  end

  // Arm requests to a queue that is not full start the deadline split on the accepting edge.
  stq_deadline u_deadline (
    .clk     (clk),
    .rst     (rst),
    .start   (dl_start),
    .delay   (req.delay_ms),
    .now_sec (time_sec),
    .now_ms  (time_ms),
    .done    (dl_done),
    .dl_sec  (dl_sec),
    .dl_ms   (dl_ms)
  );

  stq_seq #(
    .MAX_TIMERS   (MAX_TIMERS),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .res_free (res_free),
    .now_sec  (time_sec),
    .now_ms   (time_ms),
    .dl_start (dl_start),
    .dl_done  (dl_done),
    .dl_sec   (dl_sec),
    .dl_ms    (dl_ms),
    .ctl      (ctl)
  );

  // Output register: free when empty or draining this cycle.
  assign res_free = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.res_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Time fields are sampled at load, after any tick update of this request.
  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      out_status <= ctl.res_status;
      out_task   <= ctl.res_task;
      out_sec    <= time_sec;
      out_ms     <= time_ms;
      out_last   <= ctl.res_last;
    end
  end

  assign res.valid        = out_valid;
  assign res.status       = out_status;
  assign res.expired_task = out_task;
  assign res.now_seconds  = out_sec;
  assign res.now_millis   = out_ms;
  assign res.last         = out_last;

endmodule

>>> design/stq_checker.sv
// Port-level assertions for the sorted timer event queue, bound to the top level.
module stq_checker import stq_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  status,
  input logic [7:0]  expired_task,
  input logic [31:0] now_seconds,
  input logic [9:0]  now_millis,
  input logic        last
);

  // Hold a stalled result unchanged.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid &&
      $stable({status, expired_task, now_seconds, now_millis, last}))
    else $error("result changed while stalled");

  a_millis_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> now_millis < MS_PER_SEC)
    else $error("millisecond field out of range");

  a_none_due: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_NONE_DUE |-> last && expired_task == 8'd0)
    else $error("none-due result not final or carries a task");

  // Only expiries come in bursts, and no new request starts inside one.
  a_burst: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last |-> status == ST_EXPIRED && !req_ready && !(req_valid && req_ready))
    else $error("non-final result outside an expiry burst");

endmodule

bind sorted_timer_event_queue_core stq_checker u_stq_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .status       (res.status),
  .expired_task (res.expired_task),
  .now_seconds  (res.now_seconds),
  .now_millis   (res.now_millis),
  .last         (res.last)
);

>>> tb/sorted_timer_event_queue_core_checker.sv
// Checker for the sorted timer event queue: tracks the timer queue and compares every result.
module sorted_timer_event_queue_core_checker import stq_pkg::*; #(
  parameter int MAX_TIMERS   = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [9:0] cfg_wr_data,
  stq_req_if         req,
  stq_res_if         res,
  output int         fail_count,
  output int         expected_left,
  output int         results_checked,
  output int         expiries_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] TASK_MASK = 8'((1 << TASK_ID_BITS) - 1);
  localparam int         PRINT_CAP = 40;

  typedef struct packed {
    status_t     status;
    logic [7:0]  task_id;
    logic [31:0] seconds;
    logic [9:0]  millis;
    logic        last;
  } timer_result_t;

  timer_result_t pending_results[$];
  timer_result_t want;

  // Shadow of the deadline-sorted queue, head at index 0.
  logic [31:0] due_sec [MAX_TIMERS];
  logic [9:0]  due_ms  [MAX_TIMERS];
  logic [7:0]  owner   [MAX_TIMERS];
  int          live_count;
  logic [31:0] clock_sec;
  logic [9:0]  clock_ms;
  logic [9:0]  step_ms;

  logic [7:0]  tid;
  logic [31:0] dsec;
  logic [10:0] dms;
  int          pos;
  int          fired;
  int          j;
  logic        replied;

  function automatic logic due_by(logic [31:0] as, logic [9:0] am,
                                  logic [31:0] bs, logic [9:0] bm);
    return (as < bs) || (as == bs && am <= bm);
  endfunction

  task automatic drop_entry(int at);
    int k;
    for (k = at; k + 1 < live_count; k++) begin
      due_sec[k] = due_sec[k + 1];
      due_ms[k]  = due_ms[k + 1];
      owner[k]   = owner[k + 1];
    end
    live_count--;
  endtask

  task automatic expect_result(status_t st, logic [7:0] task_id);
    timer_result_t r;
    r.status  = st;
    r.task_id = task_id;
    r.seconds = clock_sec;
    r.millis  = clock_ms;
    r.last    = 1'b0;
    pending_results.push_back(r);
  endtask

  task automatic report_mismatch(string what);
    fail_count++;
    if (fail_count <= PRINT_CAP) $display("[%0t] MISMATCH %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      live_count = 0;
      clock_sec  = '0;
      clock_ms   = '0;
      step_ms    = STEP_RESET;
      pending_results.delete();
    end else begin
      if (cfg_wr_en) step_ms = cfg_wr_data;

      if (res.valid && res.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result: status %0d task %0d",
                                    res.status, res.expired_task));
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (want.status == ST_EXPIRED) expiries_checked++;
          if (res.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", res.status, want.status));
          if (res.expired_task !== want.task_id)
            report_mismatch($sformatf("expired_task %0d, want %0d",
                                      res.expired_task, want.task_id));
          if (res.now_seconds !== want.seconds)
            report_mismatch($sformatf("now_seconds %0d, want %0d",
                                      res.now_seconds, want.seconds));
          if (res.now_millis !== want.millis)
            report_mismatch($sformatf("now_millis %0d, want %0d",
                                      res.now_millis, want.millis));
          if (res.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", res.last, want.last));
        end
      end

      if (req.valid && req.ready) begin
        tid     = req.task_id & TASK_MASK;
        replied = 1'b1;
        case (req.req_type)
          REQ_TICK: begin
            dms = 11'(clock_ms) + 11'((step_ms > STEP_MAX) ? STEP_MAX : step_ms);
            if (dms >= 11'(MS_PER_SEC)) begin
              dms       = dms - 11'(MS_PER_SEC);
              clock_sec = clock_sec + 32'd1;
            end
            clock_ms = dms[9:0];
            fired    = 0;
            while (live_count > 0 && fired < RESULTS_CAP &&
                   due_by(due_sec[0], due_ms[0], clock_sec, clock_ms)) begin
              expect_result(ST_EXPIRED, owner[0]);
              drop_entry(0);
              fired++;
            end
            if (fired == 0) expect_result(ST_NONE_DUE, 8'd0);
          end
          REQ_ARM: begin
            if (live_count >= MAX_TIMERS) begin
              expect_result(ST_FULL, tid);
            end else begin
              dsec = clock_sec + req.delay_ms / 32'(MS_PER_SEC);
              dms  = 11'(clock_ms) + 11'(req.delay_ms % 32'(MS_PER_SEC));
              if (dms >= 11'(MS_PER_SEC)) begin
                dms  = dms - 11'(MS_PER_SEC);
                dsec = dsec + 32'd1;
              end
              // New entry goes ahead of any equal deadline.
              pos = 0;
              while (pos < live_count && !due_by(dsec, dms[9:0], due_sec[pos], due_ms[pos]))
                pos++;
              for (j = live_count; j > pos; j--) begin
                due_sec[j] = due_sec[j - 1];
                due_ms[j]  = due_ms[j - 1];
                owner[j]   = owner[j - 1];
              end
              due_sec[pos] = dsec;
              due_ms[pos]  = dms[9:0];
              owner[pos]   = tid;
              live_count++;
              expect_result(ST_ARMED, tid);
            end
          end
          REQ_CANCEL: begin
            pos = 0;
            while (pos < live_count && owner[pos] != tid) pos++;
            if (pos < live_count) begin
              drop_entry(pos);
              expect_result(ST_CANCELLED, tid);
            end else begin
              expect_result(ST_NOT_FOUND, tid);
            end
          end
          default: replied = 1'b0;
        endcase
        if (replied) pending_results[pending_results.size() - 1].last = 1'b1;
      end
    end
    expected_left = pending_results.size();
  end

endmodule

>>> tb/sorted_timer_event_queue_core_tb.sv
// Testbench top for the sorted timer event queue: clock, reset, stimulus and verdict.
module sorted_timer_event_queue_core_tb import stq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         MAX_TIMERS      = 16;
  localparam int         TASK_ID_BITS    = 8;
  localparam logic [1:0] REQ_RESERVED    = 2'd3;  // request kind the block ignores
  localparam int         DRAIN_CYCLES    = 80;    // longer than a full tick walk
  localparam int         HOLD_OFF_CYCLES = 400;
  localparam int         CYCLE_LIMIT     = 400000;
  localparam int         PHASE_ITEMS     = 32;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [9:0] cfg_wr_data;

  stq_req_if req_ch ();
  stq_res_if res_ch ();

  int fail_count;
  int expected_left;
  int results_checked;
  int expiries_checked;

  // Stimulus bookkeeping.
  logic [9:0] step_now;
  bit         idle_on;
  int         hold_offs_requested;
  int         hold_offs_done = 0;
  int         items_sent;
  int         steps_written;
  int         cycle_count = 0;
  int         phase;
  logic [9:0] phase_steps [8];

  sorted_timer_event_queue_core #(
    .MAX_TIMERS  (MAX_TIMERS),
    .TASK_ID_BITS(TASK_ID_BITS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .res        (res_ch)
  );

  sorted_timer_event_queue_core_checker #(
    .MAX_TIMERS  (MAX_TIMERS),
    .TASK_ID_BITS(TASK_ID_BITS)
  ) timer_queue_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .req             (req_ch),
    .res             (res_ch),
    .fail_count      (fail_count),
    .expected_left   (expected_left),
    .results_checked (results_checked),
    .expiries_checked(expiries_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_timer_event_queue_core test failed");
      $finish;
    end
  end

  // Result sink: owns res ready. Drop ready at random while idling is on, and
  // serve any pending hold-off request by holding ready low for a long stretch
  // so the single output register fills and the request side backs up.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_offs_done < hold_offs_requested) begin
        hold_offs_done++;
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      res_ch.ready <= !(idle_on && $urandom_range(99) < 31);
    end
  end

  // Effective step as the block applies it; sizes random delays to the step.
  function automatic int unsigned eff_step();
    return 32'((step_now > STEP_MAX) ? STEP_MAX : step_now);
  endfunction

  function automatic logic [31:0] near_delay();
    return $urandom_range(0, 4 * eff_step() + 3);
  endfunction

  // Mostly a small pool of task ids so cancels hit live entries.
  function automatic logic [7:0] pick_task();
    if ($urandom_range(99) < 70) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one request transaction; return at the falling edge after it is taken.
  // Valid stays high on return so the next call can go back to back.
  task automatic send_request(logic [1:0] kind, logic [7:0] tid, logic [31:0] dly);
    while (idle_on && $urandom_range(99) < 31) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.task_id  <= tid;
    req_ch.delay_ms <= dly;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    if (kind != REQ_RESERVED) items_sent++;
  endtask

  // Drop valid, wait for every expected result, then let the block settle.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write the tick step; only ever called with the block idle.
  task automatic write_step(logic [9:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    step_now = value;
    steps_written++;
  endtask

  // Fill the queue past capacity with entries due within one step, then tick:
  // the first tick should flush a burst of expiries, the overflow arms get full.
  task automatic fill_and_flush();
    repeat (MAX_TIMERS + 2) send_request(REQ_ARM, pick_task(), $urandom_range(0, eff_step()));
    repeat (2) send_request(REQ_TICK, 8'($urandom_range(0, 255)), $urandom);
  endtask

  // Random episodes until the phase quota of counted requests is reached.
  task automatic run_traffic(int quota);
    int         target;
    int         pick;
    logic [7:0] tid;
    target = items_sent + quota;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        // arm a few near timers, tick them out, maybe cancel one
        repeat ($urandom_range(1, 4)) send_request(REQ_ARM, pick_task(), near_delay());
        repeat ($urandom_range(1, 5))
          send_request(REQ_TICK, 8'($urandom_range(0, 255)), $urandom);
        if ($urandom_range(1)) send_request(REQ_CANCEL, pick_task(), $urandom);
      end else if (pick < 58) begin
        fill_and_flush();
      end else if (pick < 75) begin
        // arm far in the future, then withdraw it
        tid = pick_task();
        send_request(REQ_ARM, tid, $urandom);
        send_request(REQ_CANCEL, tid, $urandom);
      end else begin
        // noise: any kind, any field value
        send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom);
      end
    end
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = STEP_RESET;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_TICK;
    req_ch.task_id      = 8'd0;
    req_ch.delay_ms     = 32'd0;
    step_now            = STEP_RESET;
    idle_on             = 1'b1;
    hold_offs_requested = 0;
    items_sent          = 0;
    steps_written       = 0;
    phase_steps         = '{10'd10, 10'd999, 10'd1, 10'd0, 10'd1023, 10'd500, 10'd0, 10'd1};
    phase_steps[6]      = 10'($urandom_range(2, 998));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, reset step of 10 ms.
    send_request(REQ_TICK, 8'd0, 32'd0);                // empty queue: none due
    send_request(REQ_ARM, 8'd0, 32'd0);                 // zero delay: due right now
    send_request(REQ_ARM, 8'd255, 32'hFFFF_FFFF);       // largest delay, top task id
    send_request(REQ_ARM, 8'd1, 32'd999);               // ms sum passes 1000 and wraps
    send_request(REQ_ARM, 8'd2, 32'd1000);              // whole second
    send_request(REQ_ARM, 8'd3, 32'd1000);              // equal deadline: goes ahead of 2
    send_request(REQ_CANCEL, 8'd2, 32'd0);              // cancelled
    send_request(REQ_CANCEL, 8'd200, 32'hFFFF_FFFF);    // not found
    send_request(REQ_RESERVED, 8'd255, 32'hFFFF_FFFF);  // ignored, no result
    send_request(REQ_TICK, 8'd255, 32'hFFFF_FFFF);      // expire task 0
    write_step(10'd999);
    send_request(REQ_TICK, 8'd0, 32'd0);                // time wraps into second 1: 1 and 3
    send_request(REQ_CANCEL, 8'd255, 32'd0);            // withdraw the far entry
    write_step(10'd0);
    send_request(REQ_ARM, 8'd5, 32'd0);
    send_request(REQ_TICK, 8'd0, 32'd0);                // zero step still expires task 5
    write_step(10'd1023);
    send_request(REQ_TICK, 8'd0, 32'd0);                // step clamped to 999
    write_step(10'd1000);
    send_request(REQ_TICK, 8'd0, 32'd0);

    // Full queue and a sixteen-deep expiry burst while the sink is held off.
    hold_offs_requested <= hold_offs_requested + 1;
    fill_and_flush();

    // Random phases over a spread of step settings; one phase never idles,
    // one starts under a long result hold-off.
    for (phase = 0; phase < 8; phase++) begin
      write_step(phase_steps[phase]);
      idle_on <= (phase != 2);
      if (phase == 5) hold_offs_requested <= hold_offs_requested + 1;
      run_traffic(PHASE_ITEMS);
    end

    wait_drained();
    $display("Covered %0d requests under %0d step settings, %0d long result hold-offs.",
             items_sent, steps_written, hold_offs_done);
    $display("Checked %0d results, %0d of them expiries.", results_checked, expiries_checked);
    if (fail_count == 0 && expected_left == 0) begin
      $display("sorted_timer_event_queue_core test passed");
    end else begin
      $display("sorted_timer_event_queue_core test failed");
    end
    $finish;
  end

endmodule

>>> sorted_timer_event_queue_core.f
design/stq_pkg.sv
design/stq_if.sv
design/stq_ram.sv
design/stq_deadline.sv
design/stq_seq.sv
design/sorted_timer_event_queue_core.sv
design/stq_checker.sv
tb/sorted_timer_event_queue_core_checker.sv
tb/sorted_timer_event_queue_core_tb.sv
